>>> hw/rtl/tgap_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgap_pkg
// types and constants shared by the tga true-colour stream parser
// ----------------------------------------------------------------------------
package tgap_pkg;

   // header layout
   localparam int unsigned HDR_LEN_BYTES = 18;
   localparam int unsigned CNT_W         = 5;

   localparam logic [CNT_W-1:0] HDR_IDX_ID_LEN    = CNT_W'(0);
   localparam logic [CNT_W-1:0] HDR_IDX_CMAP_TYPE = CNT_W'(1);
   localparam logic [CNT_W-1:0] HDR_IDX_IMG_TYPE  = CNT_W'(2);
   localparam logic [CNT_W-1:0] HDR_IDX_CMAP_B0   = CNT_W'(3);
   localparam logic [CNT_W-1:0] HDR_IDX_CMAP_B1   = CNT_W'(4);
   localparam logic [CNT_W-1:0] HDR_IDX_CMAP_B2   = CNT_W'(5);
   localparam logic [CNT_W-1:0] HDR_IDX_CMAP_B3   = CNT_W'(6);
   localparam logic [CNT_W-1:0] HDR_IDX_X_LO      = CNT_W'(8);
   localparam logic [CNT_W-1:0] HDR_IDX_X_HI      = CNT_W'(9);
   localparam logic [CNT_W-1:0] HDR_IDX_Y_LO      = CNT_W'(10);
   localparam logic [CNT_W-1:0] HDR_IDX_Y_HI      = CNT_W'(11);
   localparam logic [CNT_W-1:0] HDR_IDX_WIDTH_LO  = CNT_W'(12);
   localparam logic [CNT_W-1:0] HDR_IDX_WIDTH_HI  = CNT_W'(13);
   localparam logic [CNT_W-1:0] HDR_IDX_HEIGHT_LO = CNT_W'(14);
   localparam logic [CNT_W-1:0] HDR_IDX_HEIGHT_HI = CNT_W'(15);
   localparam logic [CNT_W-1:0] HDR_IDX_BPP       = CNT_W'(16);
   localparam logic [CNT_W-1:0] HDR_IDX_LAST      = CNT_W'(HDR_LEN_BYTES - 1);

   localparam logic [7:0] IMG_TYPE_TRUECOLOR = 8'd2;
   localparam logic [7:0] BPP_24             = 8'd24;
   localparam logic [7:0] BPP_32             = 8'd32;

   typedef enum logic [1:0] {
      PHASE_HEADER = 2'd0,
      PHASE_PIXELS = 2'd1,
      PHASE_IGNORE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_PIXEL       = 2'd0,
      KIND_HEADER_OK   = 2'd1,
      KIND_UNSUPPORTED = 2'd2
   } kind_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       file_start;
   } req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [15:0] image_width;
      logic [15:0] image_height;
      logic [15:0] pixel_row;
      logic [15:0] pixel_column;
      logic [7:0]  first_byte;
      logic [7:0]  second_byte;
      logic [7:0]  third_byte;
      logic [7:0]  fourth_byte;
      logic        has_alpha;
      logic        last_pixel;
   } rsp_type;

endpackage

>>> hw/rtl/tgap_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgap_in_stage
// input register: holds one byte transaction until the parser takes it
// ----------------------------------------------------------------------------
module tgap_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  tgap_pkg::req_type req_data,
   input  logic             take,
   output logic             held_valid,
   output tgap_pkg::req_type held_req
);
   import tgap_pkg::*;

   logic    valid_ff, valid_in;
   req_type req_ff, req_in;
   logic    accept;

   // a held byte that the parser cannot take blocks the upstream side
   assign req_stall = valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      valid_in = valid_ff;
      req_in   = req_ff;
      if (accept) begin
         valid_in = 1'b1;
         req_in   = req_data;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      req_ff <= req_in;
   end

   assign held_valid = valid_ff;
   assign held_req   = req_ff;

endmodule

>>> hw/rtl/tgap_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgap_parser
// header check, pixel assembly and row / column counting for one byte
// ----------------------------------------------------------------------------
module tgap_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  tgap_pkg::req_type req,
   output logic              res_valid,
   output tgap_pkg::rsp_type res
);
   import tgap_pkg::*;

   phase_type        phase_ff, phase_in, phase_c;
   logic [CNT_W-1:0] hcnt_ff, hcnt_in, hcnt_c;
   logic             bad_ff, bad_in, bad_c;
   logic [15:0]      width_ff, width_in, width_c;
   logic [15:0]      height_ff, height_in, height_c;
   logic             four_ff, four_in, four_c;
   logic [23:0]      held_ff, held_in, held_c;
   logic [1:0]       bip_ff, bip_in, bip_c;
   logic [15:0]      col_ff, col_in, col_c;
   logic [15:0]      row_ff, row_in, row_c;

   logic [7:0]  b;
   logic        restart;
   logic        bad_byte;
   logic        hdr_done;
   logic        pix_done;
   logic        last;
   logic [15:0] col_inc;
   logic [23:0] held_full;

   assign b       = req.data_byte;
   assign restart = fire && req.file_start;

   // state as seen by this byte, after a possible file restart
   always_comb begin
      if (restart) begin
         phase_c  = PHASE_HEADER;
         hcnt_c   = '0;
         bad_c    = 1'b0;
         width_c  = '0;
         height_c = '0;
         four_c   = 1'b0;
         held_c   = '0;
         bip_c    = '0;
         col_c    = '0;
         row_c    = '0;
      end else begin
         phase_c  = phase_ff;
         hcnt_c   = hcnt_ff;
         bad_c    = bad_ff;
         width_c  = width_ff;
         height_c = height_ff;
         four_c   = four_ff;
         held_c   = held_ff;
         bip_c    = bip_ff;
         col_c    = col_ff;
         row_c    = row_ff;
      end
   end

   // header field check for the current byte position
   always_comb begin
      case (hcnt_c)
         HDR_IDX_ID_LEN, HDR_IDX_CMAP_TYPE, HDR_IDX_CMAP_B0, HDR_IDX_CMAP_B1,
         HDR_IDX_CMAP_B2, HDR_IDX_CMAP_B3, HDR_IDX_X_LO, HDR_IDX_X_HI,
         HDR_IDX_Y_LO, HDR_IDX_Y_HI: bad_byte = (b != 8'd0);
         HDR_IDX_IMG_TYPE:           bad_byte = (b != IMG_TYPE_TRUECOLOR);
         HDR_IDX_BPP:                bad_byte = (b != BPP_24) && (b != BPP_32);
         default:                    bad_byte = 1'b0;
      endcase
   end

   assign hdr_done  = fire && (phase_c == PHASE_HEADER) && (hcnt_c == HDR_IDX_LAST);
   assign pix_done  = fire && (phase_c == PHASE_PIXELS) &&
                      (({1'b0, bip_c} + 3'd1) >= (four_c ? 3'd4 : 3'd3));
   assign held_full = four_c ? held_c : (held_c | {b, 16'h0000});
   assign col_inc   = col_c + 16'd1;
   assign last      = (({1'b0, row_c} + 17'd1) >= {1'b0, height_c}) &&
                      (({1'b0, col_c} + 17'd1) >= {1'b0, width_c});

   // next state
   always_comb begin
      phase_in  = phase_c;
      hcnt_in   = hcnt_c;
      bad_in    = bad_c;
      width_in  = width_c;
      height_in = height_c;
      four_in   = four_c;
      held_in   = held_c;
      bip_in    = bip_c;
      col_in    = col_c;
      row_in    = row_c;
      if (fire) begin
         case (phase_c)
            PHASE_HEADER: begin
               bad_in = bad_c | bad_byte;
               case (hcnt_c)
                  HDR_IDX_WIDTH_LO:  width_in  = {8'h00, b};
                  HDR_IDX_WIDTH_HI:  width_in  = width_c | {b, 8'h00};
                  HDR_IDX_HEIGHT_LO: height_in = {8'h00, b};
                  HDR_IDX_HEIGHT_HI: height_in = height_c | {b, 8'h00};
                  HDR_IDX_BPP: begin
                     if (b == BPP_24) begin
                        four_in = 1'b0;
                     end else if (b == BPP_32) begin
                        four_in = 1'b1;
                     end
                  end
                  default: ;
               endcase
               if (hcnt_c == HDR_IDX_LAST) begin
                  hcnt_in = '0;
                  if (bad_in) begin
                     phase_in = PHASE_IGNORE;
                  end else begin
                     phase_in = ((width_c == 16'd0) || (height_c == 16'd0)) ?
                                PHASE_IGNORE : PHASE_PIXELS;
                     bip_in   = '0;
                     held_in  = '0;
                     col_in   = '0;
                     row_in   = '0;
                  end
               end else begin
                  hcnt_in = hcnt_c + CNT_W'(1);
               end
            end
            PHASE_PIXELS: begin
               if (!pix_done) begin
                  case (bip_c)
                     2'd0:    held_in = held_c | {16'h0000, b};
                     2'd1:    held_in = held_c | {8'h00, b, 8'h00};
                     default: held_in = held_c | {b, 16'h0000};
                  endcase
                  bip_in = bip_c + 2'd1;
               end else begin
                  bip_in  = '0;
                  held_in = '0;
                  if (col_inc >= width_c) begin
                     col_in = '0;
                     row_in = row_c + 16'd1;
                  end else begin
                     col_in = col_inc;
                  end
                  if (last) begin
                     phase_in = PHASE_IGNORE;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   // result of this byte
   always_comb begin
      res       = '0;
      res_valid = hdr_done || pix_done;
      if (hdr_done) begin
         res.result_kind  = (bad_c | bad_byte) ? KIND_UNSUPPORTED : KIND_HEADER_OK;
         res.image_width  = width_c;
         res.image_height = height_c;
      end else if (pix_done) begin
         res.result_kind  = KIND_PIXEL;
         res.pixel_row    = row_c;
         res.pixel_column = width_c - 16'd1 - col_c;
         res.first_byte   = held_full[7:0];
         res.second_byte  = held_full[15:8];
         res.third_byte   = held_full[23:16];
         res.fourth_byte  = four_c ? b : 8'h00;
         res.has_alpha    = four_c;
         res.last_pixel   = last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PHASE_HEADER;
         hcnt_ff   <= '0;
         bad_ff    <= 1'b0;
         width_ff  <= '0;
         height_ff <= '0;
         four_ff   <= 1'b0;
         held_ff   <= '0;
         bip_ff    <= '0;
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         phase_ff  <= phase_in;
         hcnt_ff   <= hcnt_in;
         bad_ff    <= bad_in;
         width_ff  <= width_in;
         height_ff <= height_in;
         four_ff   <= four_in;
         held_ff   <= held_in;
         bip_ff    <= bip_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

endmodule

>>> hw/rtl/tgap_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgap_out_stage
// result register: holds one result transaction until downstream takes it
// ----------------------------------------------------------------------------
module tgap_out_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              res_valid,
   input  tgap_pkg::rsp_type res,
   output logic              can_load,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tgap_pkg::rsp_type rsp_out
);
   import tgap_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type rsp_ff, rsp_in;

   assign can_load = !valid_ff || !rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (can_load) begin
         valid_in = res_valid;
         rsp_in   = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_out   = rsp_ff;

endmodule

>>> hw/rtl/tga_truecolor_stream_parser_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tga_truecolor_stream_parser_core
// byte stream parser for uncompressed 24/32-bit true-colour tga files
//
//   channel   direction   handshake             payload
//   req_      in          req_valid/req_stall   data_byte, file_start
//   rsp_      out         rsp_valid/rsp_stall   header or pixel result
//
// one byte is taken every cycle while req_stall is low; a byte that completes a header
// or a pixel has its result on rsp_ once it has passed the input register, then the result register
// the parser state advances as a byte moves from the input to the result
// register, so a stall on rsp_ reaches req_stall in the same cycle
// reset clears all parser state to the header phase and empties both stages
// ----------------------------------------------------------------------------
module tga_truecolor_stream_parser_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_file_start,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_result_kind,
   output logic [15:0] rsp_image_width,
   output logic [15:0] rsp_image_height,
   output logic [15:0] rsp_pixel_row,
   output logic [15:0] rsp_pixel_column,
   output logic [7:0]  rsp_first_byte,
   output logic [7:0]  rsp_second_byte,
   output logic [7:0]  rsp_third_byte,
   output logic [7:0]  rsp_fourth_byte,
   output logic        rsp_has_alpha,
   output logic        rsp_last_pixel
);
   import tgap_pkg::*;

   req_type req_bus, held_req;
   rsp_type res, rsp_bus;
   logic    held_valid;
   logic    can_load;
   logic    fire;
   logic    res_valid;

   assign req_bus.data_byte  = req_data_byte;
   assign req_bus.file_start = req_file_start;
   assign fire               = held_valid && can_load;

   tgap_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_bus),
      .take       (can_load),
      .held_valid (held_valid),
      .held_req   (held_req)
   );

   tgap_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .req       (held_req),
      .res_valid (res_valid),
      .res       (res)
   );

   tgap_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .res_valid (res_valid),
      .res       (res),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_out   (rsp_bus)
   );

   assign rsp_result_kind  = rsp_bus.result_kind;
   assign rsp_image_width  = rsp_bus.image_width;
   assign rsp_image_height = rsp_bus.image_height;
   assign rsp_pixel_row    = rsp_bus.pixel_row;
   assign rsp_pixel_column = rsp_bus.pixel_column;
   assign rsp_first_byte   = rsp_bus.first_byte;
   assign rsp_second_byte  = rsp_bus.second_byte;
   assign rsp_third_byte   = rsp_bus.third_byte;
   assign rsp_fourth_byte  = rsp_bus.fourth_byte;
   assign rsp_has_alpha    = rsp_bus.has_alpha;
   assign rsp_last_pixel   = rsp_bus.last_pixel;

endmodule

>>> hw/rtl/tgap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tgap_checker
// port-level checks on the result channel of the tga stream parser
// ----------------------------------------------------------------------------
module tgap_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_result_kind,
   input logic [15:0] rsp_image_width,
   input logic [15:0] rsp_pixel_row,
   input logic [15:0] rsp_pixel_column,
   input logic [7:0]  rsp_first_byte,
   input logic [7:0]  rsp_fourth_byte,
   input logic        rsp_has_alpha,
   input logic        rsp_last_pixel
);
   import tgap_pkg::*;

   // nothing is left in the result register after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // header transactions carry no pixel content
   a_header_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind != KIND_PIXEL)) |->
      (rsp_pixel_row == 16'd0) && (rsp_pixel_column == 16'd0) &&
      (rsp_first_byte == 8'd0) && !rsp_has_alpha && !rsp_last_pixel)
      else $error("header result carries pixel fields");

   // pixel transactions carry no image width and 24-bit pixels no alpha
   a_pixel_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_result_kind == KIND_PIXEL)) |->
      (rsp_image_width == 16'd0) && (rsp_has_alpha || (rsp_fourth_byte == 8'd0)))
      else $error("pixel result carries stray fields");

   // a stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=>
      rsp_valid && $stable(rsp_result_kind) && $stable(rsp_pixel_row) &&
      $stable(rsp_pixel_column) && $stable(rsp_first_byte))
      else $error("stalled result changed");

endmodule

bind tga_truecolor_stream_parser_core tgap_checker u_tgap_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_result_kind  (rsp_result_kind),
   .rsp_image_width  (rsp_image_width),
   .rsp_pixel_row    (rsp_pixel_row),
   .rsp_pixel_column (rsp_pixel_column),
   .rsp_first_byte   (rsp_first_byte),
   .rsp_fourth_byte  (rsp_fourth_byte),
   .rsp_has_alpha    (rsp_has_alpha),
   .rsp_last_pixel   (rsp_last_pixel)
);

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// testbench for the tga true-colour stream parser core
//
// a short table of directed bytes is followed by randomly composed files:
// complete 24/32-bit images, empty images, rejected headers, truncated files
// and noise. every accepted byte runs through a local parser model whose
// results are queued and compared field by field with each rsp_ transaction.
// the sender works in bursts with gaps, the receiver stalls in changing modes
// ----------------------------------------------------------------------------
module tb_top;
   import tgap_pkg::*;

   localparam int HALF_PERIOD_NS = 5;
   localparam int RESET_CYCLES   = 10;
   localparam int DIRECTED_ROWS  = 23;
   localparam int RANDOM_ITEMS   = 1100;
   localparam int DRAIN_CYCLES   = 8;
   // longest quiet stretch: longest receiver stall plus longest sender gap plus
   // two pipeline stages; taken many times over
   localparam int IDLE_LIMIT     = 2000;

   typedef struct packed {
      logic       start;
      logic [7:0] data;
      logic       typed;
      rsp_type    rsp;
   } byte_item_type;

   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_LONG
   } stall_mode_type;

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte  = 8'h00;
   logic        req_file_start = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b0;
   logic [1:0]  rsp_result_kind;
   logic [15:0] rsp_image_width;
   logic [15:0] rsp_image_height;
   logic [15:0] rsp_pixel_row;
   logic [15:0] rsp_pixel_column;
   logic [7:0]  rsp_first_byte;
   logic [7:0]  rsp_second_byte;
   logic [7:0]  rsp_third_byte;
   logic [7:0]  rsp_fourth_byte;
   logic        rsp_has_alpha;
   logic        rsp_last_pixel;

   byte_item_type  byte_plan[$];
   rsp_type        expected_results[$];
   int unsigned    drive_idx   = 0;
   int unsigned    burst_left  = 0;
   int unsigned    gap_left    = 0;
   int unsigned    idle_cycles = 0;
   int unsigned    cycle_count = 0;
   int unsigned    stall_left  = 0;
   stall_mode_type stall_mode  = STALL_NONE;
   int unsigned    fail_count  = 0;

   // parser model state
   phase_type   phase_q;
   logic [4:0]  hdr_count;
   logic        hdr_bad;
   logic [15:0] img_w;
   logic [15:0] img_h;
   logic        alpha_mode;
   logic [23:0] held;
   logic [1:0]  byte_pos;
   logic [15:0] col_q;
   logic [15:0] row_q;

   tga_truecolor_stream_parser_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data_byte    (req_data_byte),
      .req_file_start   (req_file_start),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_pixel_row    (rsp_pixel_row),
      .rsp_pixel_column (rsp_pixel_column),
      .rsp_first_byte   (rsp_first_byte),
      .rsp_second_byte  (rsp_second_byte),
      .rsp_third_byte   (rsp_third_byte),
      .rsp_fourth_byte  (rsp_fourth_byte),
      .rsp_has_alpha    (rsp_has_alpha),
      .rsp_last_pixel   (rsp_last_pixel)
   );

   always #HALF_PERIOD_NS clock = ~clock;

   function automatic void clear_parser_model();
      phase_q    = PHASE_HEADER;
      hdr_count  = '0;
      hdr_bad    = 1'b0;
      img_w      = '0;
      img_h      = '0;
      alpha_mode = 1'b0;
      held       = '0;
      byte_pos   = '0;
      col_q      = '0;
      row_q      = '0;
   endfunction

   // advances the model by one byte; returns 1 when the byte completes a result
   function automatic bit parse_tga_byte(input logic [7:0] b, input logic start,
                                         output rsp_type res);
      bit produced;
      bit last;
      res      = '0;
      produced = 1'b0;
      if (start) clear_parser_model();
      case (phase_q)
         PHASE_HEADER: begin
            case (hdr_count)
               HDR_IDX_ID_LEN, HDR_IDX_CMAP_TYPE, HDR_IDX_CMAP_B0, HDR_IDX_CMAP_B1,
               HDR_IDX_CMAP_B2, HDR_IDX_CMAP_B3, HDR_IDX_X_LO, HDR_IDX_X_HI,
               HDR_IDX_Y_LO, HDR_IDX_Y_HI: begin
                  if (b != 8'h00) hdr_bad = 1'b1;
               end
               HDR_IDX_IMG_TYPE: begin
                  if (b != IMG_TYPE_TRUECOLOR) hdr_bad = 1'b1;
               end
               HDR_IDX_WIDTH_LO:  img_w = {8'h00, b};
               HDR_IDX_WIDTH_HI:  img_w[15:8] = b;
               HDR_IDX_HEIGHT_LO: img_h = {8'h00, b};
               HDR_IDX_HEIGHT_HI: img_h[15:8] = b;
               HDR_IDX_BPP: begin
                  if (b == BPP_24) alpha_mode = 1'b0;
                  else if (b == BPP_32) alpha_mode = 1'b1;
                  else hdr_bad = 1'b1;
               end
               default: ;
            endcase
            if (hdr_count != HDR_IDX_LAST) begin
               hdr_count = hdr_count + 5'd1;
            end else begin
               produced         = 1'b1;
               hdr_count        = '0;
               res.image_width  = img_w;
               res.image_height = img_h;
               if (hdr_bad) begin
                  res.result_kind = KIND_UNSUPPORTED;
                  phase_q         = PHASE_IGNORE;
               end else begin
                  res.result_kind = KIND_HEADER_OK;
                  // empty image: header reported, everything after it ignored
                  phase_q  = (img_w == 16'd0 || img_h == 16'd0) ? PHASE_IGNORE
                                                                : PHASE_PIXELS;
                  byte_pos = '0;
                  held     = '0;
                  col_q    = '0;
                  row_q    = '0;
               end
            end
         end
         PHASE_PIXELS: begin
            if (int'(byte_pos) + 1 < (alpha_mode ? 4 : 3)) begin
               held[8*byte_pos +: 8] = b;
               byte_pos = byte_pos + 2'd1;
            end else begin
               produced = 1'b1;
               if (alpha_mode) res.fourth_byte = b;
               else held[23:16] = b;
               last = (int'(row_q) + 1 >= int'(img_h)) && (int'(col_q) + 1 >= int'(img_w));
               res.result_kind  = KIND_PIXEL;
               res.pixel_row    = row_q;
               res.pixel_column = img_w - 16'd1 - col_q;
               res.first_byte   = held[7:0];
               res.second_byte  = held[15:8];
               res.third_byte   = held[23:16];
               res.has_alpha    = alpha_mode;
               res.last_pixel   = last;
               byte_pos = '0;
               held     = '0;
               col_q    = col_q + 16'd1;
               if (col_q >= img_w) begin
                  col_q = '0;
                  row_q = row_q + 16'd1;
               end
               if (last) phase_q = PHASE_IGNORE;
            end
         end
         default: ;   // ignore phase and the unused code
      endcase
      return produced;
   endfunction

   // directed bytes: a stray byte before any file start, a restart that drops
   // it, a 1x1 24-bit file with extreme values, then a trailing byte
   function automatic byte_item_type directed_row(int i);
      byte_item_type r;
      r = '0;
      case (i)
         0:  r.data = 8'h55;
         1:  r.start = 1'b1;
         3:  r.data = IMG_TYPE_TRUECOLOR;
         8:  r.data = 8'hFF;   // colour map entry size is not checked
         13: r.data = 8'h01;
         15: r.data = 8'h01;
         17: r.data = BPP_24;
         18: begin
            r.data                 = 8'hFF;
            r.typed                = 1'b1;
            r.rsp.result_kind      = KIND_HEADER_OK;
            r.rsp.image_width      = 16'd1;
            r.rsp.image_height     = 16'd1;
         end
         19: r.data = 8'hFF;
         20: r.data = 8'h00;
         21: begin
            r.data                 = 8'hFF;
            r.typed                = 1'b1;
            r.rsp.result_kind      = KIND_PIXEL;
            r.rsp.first_byte       = 8'hFF;
            r.rsp.third_byte       = 8'hFF;
            r.rsp.last_pixel       = 1'b1;
         end
         22: r.data = 8'hA5;
         default: ;
      endcase
      return r;
   endfunction

   task automatic add_byte(input logic [7:0] data, input logic start);
      byte_item_type item;
      item       = '0;
      item.data  = data;
      item.start = start;
      byte_plan  = {byte_plan, item};
   endtask

   // queues the first n_bytes of a header; corrupt spoils one checked field
   task automatic add_header(input logic [15:0] w, input logic [15:0] h,
                             input logic [7:0] bpp, input bit corrupt, input int n_bytes);
      logic [7:0] hdr [HDR_LEN_BYTES];
      logic [4:0] checked [12];
      logic [4:0] idx;
      logic [7:0] bad;
      checked = '{HDR_IDX_ID_LEN, HDR_IDX_CMAP_TYPE, HDR_IDX_IMG_TYPE, HDR_IDX_CMAP_B0,
                  HDR_IDX_CMAP_B1, HDR_IDX_CMAP_B2, HDR_IDX_CMAP_B3, HDR_IDX_X_LO,
                  HDR_IDX_X_HI, HDR_IDX_Y_LO, HDR_IDX_Y_HI, HDR_IDX_BPP};
      foreach (hdr[k]) hdr[k] = 8'h00;
      hdr[HDR_IDX_IMG_TYPE]  = IMG_TYPE_TRUECOLOR;
      hdr[HDR_IDX_CMAP_B3 + 5'd1] = 8'($urandom);
      hdr[HDR_IDX_WIDTH_LO]  = w[7:0];
      hdr[HDR_IDX_WIDTH_HI]  = w[15:8];
      hdr[HDR_IDX_HEIGHT_LO] = h[7:0];
      hdr[HDR_IDX_HEIGHT_HI] = h[15:8];
      hdr[HDR_IDX_BPP]       = bpp;
      hdr[HDR_IDX_LAST]      = 8'($urandom);
      if (corrupt) begin
         idx = checked[$urandom_range(0, 11)];
         if (idx == HDR_IDX_IMG_TYPE) begin
            do bad = 8'($urandom); while (bad == IMG_TYPE_TRUECOLOR);
         end else if (idx == HDR_IDX_BPP) begin
            do bad = 8'($urandom); while (bad == BPP_24 || bad == BPP_32);
         end else begin
            bad = 8'($urandom_range(1, 255));
         end
         hdr[idx] = bad;
      end
      for (int k = 0; k < n_bytes; k++) add_byte(hdr[k], k == 0);
   endtask

   // sender: bursts of random length with random gaps; prediction on acceptance
   always @(posedge clock) begin : drive_req
      rsp_type predicted;
      bit      produced;
      bit      hold;
      if (reset) begin
         clear_parser_model();
         req_valid      <= 1'b0;
         req_data_byte  <= 8'h00;
         req_file_start <= 1'b0;
      end else begin
         hold = req_valid && req_stall;
         if (req_valid && !req_stall) begin
            produced = parse_tga_byte(byte_plan[drive_idx].data, byte_plan[drive_idx].start,
                                      predicted);
            if (byte_plan[drive_idx].typed) begin
               expected_results = {expected_results, byte_plan[drive_idx].rsp};
            end else if (produced) begin
               expected_results = {expected_results, predicted};
            end
            drive_idx++;
         end
         if (!hold) begin
            if (gap_left > 0 || drive_idx >= byte_plan.size()) begin
               req_valid <= 1'b0;
               if (gap_left > 0) gap_left--;
            end else begin
               req_valid      <= 1'b1;
               req_data_byte  <= byte_plan[drive_idx].data;
               req_file_start <= byte_plan[drive_idx].start;
               if (burst_left > 1) begin
                  burst_left--;
               end else if ($urandom_range(0, 9) == 0) begin
                  // long stretch with no idling
                  burst_left = 200;
                  gap_left   = 0;
               end else begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // receiver: stall pattern switches between randomly picked modes as cycle_count advances
   always @(posedge clock) begin : drive_rsp
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         cycle_count++;
         if (cycle_count % 128 == 0) stall_mode = stall_mode_type'($urandom_range(0, 3));
         case (stall_mode)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_PERIODIC: rsp_stall <= (cycle_count % 5 < 2);
            default: begin
               if (stall_left > 0) begin
                  stall_left--;
                  rsp_stall <= 1'b1;
               end else begin
                  rsp_stall  <= 1'b0;
                  stall_left = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 25) : 0;
               end
            end
         endcase
      end
   end

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_rsp
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0) begin
            $error("result transaction with nothing expected, kind %0d", rsp_result_kind);
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("result_kind",  16'(want.result_kind),  16'(rsp_result_kind));
            check_field("image_width",  want.image_width,       rsp_image_width);
            check_field("image_height", want.image_height,      rsp_image_height);
            check_field("pixel_row",    want.pixel_row,         rsp_pixel_row);
            check_field("pixel_column", want.pixel_column,      rsp_pixel_column);
            check_field("first_byte",   16'(want.first_byte),   16'(rsp_first_byte));
            check_field("second_byte",  16'(want.second_byte),  16'(rsp_second_byte));
            check_field("third_byte",   16'(want.third_byte),   16'(rsp_third_byte));
            check_field("fourth_byte",  16'(want.fourth_byte),  16'(rsp_fourth_byte));
            check_field("has_alpha",    16'(want.has_alpha),    16'(rsp_has_alpha));
            check_field("last_pixel",   16'(want.last_pixel),   16'(rsp_last_pixel));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("tb_top: FAIL");
      $finish;
   end

   initial begin
      int          pick;
      int          n;
      logic [15:0] w;
      logic [15:0] h;
      logic [7:0]  bpp;
      for (int i = 0; i < DIRECTED_ROWS; i++) byte_plan = {byte_plan, directed_row(i)};
      while (byte_plan.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         bpp  = ($urandom_range(0, 1) == 1) ? BPP_32 : BPP_24;
         w    = 16'($urandom);
         h    = 16'($urandom);
         if (pick < 55) begin
            // complete image, small sizes, then a few trailing bytes
            if ($urandom_range(0, 6) == 0) begin
               w = 16'($urandom_range(1, 24));
               h = 16'd1;
            end else begin
               w = 16'($urandom_range(1, 6));
               h = 16'($urandom_range(1, 4));
            end
            add_header(w, h, bpp, 1'b0, HDR_LEN_BYTES);
            n = int'(w) * int'(h) * ((bpp == BPP_32) ? 4 : 3);
            repeat (n) add_byte(8'($urandom), 1'b0);
            repeat ($urandom_range(0, 3)) add_byte(8'($urandom), 1'b0);
         end else if (pick < 65) begin
            // empty image
            if ($urandom_range(0, 1) == 1) w = 16'd0;
            else h = 16'd0;
            add_header(w, h, bpp, 1'b0, HDR_LEN_BYTES);
            repeat ($urandom_range(0, 4)) add_byte(8'($urandom), 1'b0);
         end else if (pick < 77) begin
            // rejected header, then ignored bytes
            add_header(w, h, bpp, 1'b1, HDR_LEN_BYTES);
            repeat ($urandom_range(0, 5)) add_byte(8'($urandom), 1'b0);
         end else if (pick < 88) begin
            // truncated file, often with the largest width
            if ($urandom_range(0, 1) == 1) w = 16'hFFFF;
            if (w == 16'd0) w = 16'd1;
            if (h == 16'd0) h = 16'hFFFF;
            if ($urandom_range(0, 2) == 0) begin
               add_header(w, h, bpp, 1'b0, $urandom_range(1, HDR_LEN_BYTES - 1));
            end else begin
               add_header(w, h, bpp, 1'b0, HDR_LEN_BYTES);
               repeat ($urandom_range(0, 13)) add_byte(8'($urandom), 1'b0);
            end
         end else begin
            // noise with stray file starts
            repeat ($urandom_range(1, 30)) add_byte(8'($urandom), $urandom_range(0, 7) == 0);
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (drive_idx < byte_plan.size() || expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top: PASS");
      end else begin
         $display("tb_top: FAIL");
      end
      $finish;
   end

endmodule
